// ----- rtl/core/rmfw_pkg.sv -----
// Package for the recursive mutex with FIFO wait queue.
// Holds field widths, opcode and status codes, and the structs passed between modules.
// No dependencies.
package rmfw_pkg;

	localparam int ID_W     = 4;
	localparam int CNT_W    = 8;
	localparam int LEN_W    = 5;
	localparam int ID_COUNT = 16;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		ST_ACQUIRED  = 3'd0,
		ST_NESTED    = 3'd1,
		ST_BLOCKED   = 3'd2,
		ST_UNNEST    = 3'd3,
		ST_FREED     = 3'd4,
		ST_HANDED    = 3'd5,
		ST_NOT_OWNER = 3'd6,
		ST_ERROR     = 3'd7
	} status_t;

	typedef struct packed {
		logic             held;
		logic [ID_W-1:0]  owner;
		logic [CNT_W-1:0] count;
	} lock_t;

	typedef struct packed {
		logic            push;
		logic            pop;
		logic [ID_W-1:0] push_id;
	} waitq_cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]     head_id;
		logic [LEN_W-1:0]    len;
		logic                full;
		logic [ID_COUNT-1:0] waiting;
	} waitq_stat_t;

	typedef struct packed {
		status_t          status;
		logic             wake_valid;
		logic [ID_W-1:0]  wake_thread;
		logic             owner_valid;
		logic [ID_W-1:0]  owner_id;
		logic [CNT_W-1:0] hold_count;
		logic [LEN_W-1:0] waiter_count;
	} result_t;

endpackage

// ----- rtl/core/rmfw_waitq.sv -----
// Wait queue: small circular buffer of thread ids plus a per-thread waiting bitmap.
// Depends on rmfw_pkg.
module rmfw_waitq
	import rmfw_pkg::*;
#(
	parameter int THREAD_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  waitq_cmd_t  cmd,
	output waitq_stat_t stat
);

	// Only ID_COUNT distinct ids exist and each waits at most once.
	localparam int QDEPTH = (THREAD_COUNT < ID_COUNT) ? THREAD_COUNT : ID_COUNT;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(QDEPTH);

	logic [ID_W-1:0]     mem_q [QDEPTH];
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [LEN_W-1:0]    len_q;
	logic [ID_COUNT-1:0] waiting_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[tail_q] <= cmd.push_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			len_q     <= '0;
			waiting_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q               <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
				len_q                <= len_q + 1'b1;
				waiting_q[cmd.push_id] <= 1'b1;
			end else if (cmd.pop) begin
				head_q                    <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
				len_q                     <= len_q - 1'b1;
				waiting_q[mem_q[head_q]] <= 1'b0;
			end
		end
	end

	assign stat.head_id = mem_q[head_q];
	assign stat.len     = len_q;
	assign stat.full    = (len_q >= LEN_FULL);
	assign stat.waiting = waiting_q;

endmodule

// ----- rtl/core/rmfw_ctrl.sv -----
// Request decode: next lock state, queue command and result for one request.
// Depends on rmfw_pkg; purely combinational.
module rmfw_ctrl
	import rmfw_pkg::*;
#(
	parameter int THREAD_COUNT = 16,
	parameter int NEST_LIMIT   = 255
) (
	input  logic            opcode,
	input  logic [ID_W-1:0] thread_id,
	input  lock_t           lock_cur,
	input  waitq_stat_t     wq,
	output lock_t           lock_nxt,
	output waitq_cmd_t      cmd,
	output result_t         res
);

	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(NEST_LIMIT);
	localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

	logic    id_ok;
	logic    is_owner;
	status_t st;

	assign id_ok    = (32'(thread_id) < THREAD_COUNT);
	assign is_owner = lock_cur.held && (lock_cur.owner == thread_id);

	always_comb begin
		lock_nxt    = lock_cur;
		cmd.push    = 1'b0;
		cmd.pop     = 1'b0;
		cmd.push_id = thread_id;
		st          = ST_ERROR;
		if (opcode == OP_ACQUIRE) begin
			if (!id_ok || wq.waiting[thread_id]) begin
				st = ST_ERROR;
			end else if (!lock_cur.held) begin
				lock_nxt.held  = 1'b1;
				lock_nxt.owner = thread_id;
				lock_nxt.count = ONE;
				st             = ST_ACQUIRED;
			end else if (is_owner) begin
				if (lock_cur.count >= LIMIT) begin
					lock_nxt.count = LIMIT;
					st             = ST_ERROR;
				end else begin
					lock_nxt.count = lock_cur.count + 1'b1;
					st             = ST_NESTED;
				end
			end else if (wq.full) begin
				st = ST_ERROR;
			end else begin
				cmd.push = 1'b1;
				st       = ST_BLOCKED;
			end
		end else begin
			if (!is_owner) begin
				st = ST_NOT_OWNER;
			end else if (lock_cur.count > ONE) begin
				lock_nxt.count = lock_cur.count - 1'b1;
				st             = ST_UNNEST;
			end else if (wq.len == '0) begin
				lock_nxt.held  = 1'b0;
				lock_nxt.owner = '0;
				lock_nxt.count = '0;
				st             = ST_FREED;
			end else begin
				// direct hand-off to the queue head
				cmd.pop        = 1'b1;
				lock_nxt.owner = wq.head_id;
				lock_nxt.count = ONE;
				st             = ST_HANDED;
			end
		end
	end

	always_comb begin
		res.status       = st;
		res.wake_valid   = cmd.pop;
		res.wake_thread  = cmd.pop ? wq.head_id : '0;
		res.owner_valid  = lock_nxt.held;
		res.owner_id     = lock_nxt.held ? lock_nxt.owner : '0;
		res.hold_count   = lock_nxt.held ? lock_nxt.count : '0;
		res.waiter_count = wq.len + LEN_W'(cmd.push) - LEN_W'(cmd.pop);
	end

endmodule

// ----- rtl/core/recursive_mutex_fifo_waitq_core.sv -----
// Top level of the recursive mutex with FIFO wait queue: lock state and result register.
// Depends on rmfw_pkg, rmfw_waitq, rmfw_ctrl.
//
// channel | handshake            | payload
// req     | req_valid, req_ready | opcode, thread_id
// rsp     | rsp_valid, rsp_ready | status, wake_valid, wake_thread, owner_valid,
//         |                      | owner_id, hold_count, waiter_count
//
// One request per cycle unless rsp stalls; results appear the cycle after the take.
// All state updates in the accepting cycle, so back-to-back requests see each other.
// Reset frees the lock and empties the wait queue; queue entries need no clearing.
// A stalled rsp holds its result; req_ready stays high while the result register
// is empty or being drained in the same cycle.
module recursive_mutex_fifo_waitq_core
	import rmfw_pkg::*;
#(
	parameter int THREAD_COUNT = 16,
	parameter int NEST_MAX     = 255
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic             opcode,
	input  logic [ID_W-1:0]  thread_id,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic [2:0]       status,
	output logic             wake_valid,
	output logic [ID_W-1:0]  wake_thread,
	output logic             owner_valid,
	output logic [ID_W-1:0]  owner_id,
	output logic [CNT_W-1:0] hold_count,
	output logic [LEN_W-1:0] waiter_count
);

	localparam int NEST_LIMIT = (NEST_MAX < 255) ? NEST_MAX : 255;

	lock_t       lock_q;
	lock_t       lock_nxt;
	waitq_cmd_t  wq_cmd;
	waitq_cmd_t  wq_cmd_gated;
	waitq_stat_t wq_stat;
	result_t     res;
	result_t     res_q;
	logic        rsp_valid_q;
	logic        take;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign take      = req_valid && req_ready;

	rmfw_ctrl #(
		.THREAD_COUNT (THREAD_COUNT),
		.NEST_LIMIT   (NEST_LIMIT)
	) u_ctrl (
		.opcode    (opcode),
		.thread_id (thread_id),
		.lock_cur  (lock_q),
		.wq        (wq_stat),
		.lock_nxt  (lock_nxt),
		.cmd       (wq_cmd),
		.res       (res)
	);

	always_comb begin
		wq_cmd_gated      = wq_cmd;
		wq_cmd_gated.push = wq_cmd.push && take;
		wq_cmd_gated.pop  = wq_cmd.pop && take;
	end

	rmfw_waitq #(
		.THREAD_COUNT (THREAD_COUNT)
	) u_waitq (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (wq_cmd_gated),
		.stat   (wq_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				lock_q <= lock_nxt;
			end
			if (take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = res_q.status;
	assign wake_valid   = res_q.wake_valid;
	assign wake_thread  = res_q.wake_thread;
	assign owner_valid  = res_q.owner_valid;
	assign owner_id     = res_q.owner_id;
	assign hold_count   = res_q.hold_count;
	assign waiter_count = res_q.waiter_count;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q.held |-> (lock_q.count != '0 && 32'(lock_q.count) <= NEST_LIMIT))
		else $error("nest count out of range while held");

	a_owner_not_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q.held |-> !wq_stat.waiting[lock_q.owner])
		else $error("lock owner is also queued");

	a_len_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(wq_stat.waiting) == 32'(wq_stat.len))
		else $error("queue length disagrees with waiting bitmap");

	a_wake_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && res_q.wake_valid) |->
			(res_q.status == ST_HANDED && res_q.owner_id == res_q.wake_thread
			 && res_q.hold_count == CNT_W'(1)))
		else $error("wake result inconsistent with hand-off");
`endif

endmodule
